>>> src/tlik_pkg.sv
// shared constants, types and tables for the two-link inverse kinematics block
// no dependencies
package tlik_pkg;

  localparam int AngleFracBits = 13;
  localparam int CordicIters   = 16;
  localparam int LenW          = 14;
  localparam int CoordW        = 16;
  localparam int AngW          = 16;
  localparam int ZW            = 34;   // q30 angle accumulator, signed
  localparam int CW            = 34;   // cordic x/y width, signed
  localparam int NW            = 35;   // elbow cosine numerator/denominator, signed
  localparam int SqW           = 64;   // square radicand width
  localparam int RootW         = 32;
  localparam int ItW           = 5;

  localparam logic signed [ZW-1:0] PiQ30 = 34'sd3373259426;
  localparam logic signed [AngW-1:0] PiFmt =
      AngW'((64'd3373259426 + (64'd1 << (29 - AngleFracBits))) >> (30 - AngleFracBits));

  typedef enum logic [2:0] {
    CMD_NONE, CMD_LOAD, CMD_NUM, CMD_SQRT, CMD_ATAN_BASE, CMD_ATAN_ELB,
    CMD_ATAN_OFF1, CMD_ATAN_OFF2
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic pick;
  } ctrl_t;

  typedef struct packed {
    logic busy;
  } stat_t;

  function automatic logic [ZW-1:0] atan_q30(input logic [ItW-1:0] i);
    logic [ZW-1:0] r;
    case (i)
      5'd0: r = 34'd843314857;
      5'd1: r = 34'd497837830;
      5'd2: r = 34'd263043837;
      5'd3: r = 34'd133525159;
      5'd4: r = 34'd67021687;
      5'd5: r = 34'd33543516;
      5'd6: r = 34'd16775851;
      5'd7: r = 34'd8388437;
      5'd8: r = 34'd4194283;
      5'd9: r = 34'd2097149;
      default: r = ZW'(34'd1073741824 >> i);
    endcase
    return r;
  endfunction

endpackage

>>> src/tlik_sqrt.sv
// multi-cycle integer square root, two radicand bits per cycle
// depends on tlik_pkg
module tlik_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tlik_pkg::SqW-1:0]    rad_i,
  output logic                        busy_o,
  output logic [tlik_pkg::RootW-1:0]  root_o
);
  import tlik_pkg::*;

  logic [SqW-1:0] v_q, v_d, r_q, r_d, bit_q, bit_d;
  logic busy_q, busy_d;

  always_comb begin
    v_d = v_q; r_d = r_q; bit_d = bit_q; busy_d = busy_q;
    if (start_i) begin
      v_d = rad_i; r_d = '0; bit_d = 64'd1 << 62; busy_d = 1'b1;
    end else if (busy_q) begin
      if (v_q >= r_q + bit_q) begin
        v_d = v_q - (r_q + bit_q);
        r_d = (r_q >> 1) + bit_q;
      end else begin
        r_d = r_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      busy_q <= busy_d;
      bit_q  <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    r_q <= r_d;
  end

  assign busy_o = busy_q;
  assign root_o = r_q[RootW-1:0];
endmodule

>>> src/tlik_cordic.sv
// vectoring cordic atan2, normalize then one micro-rotation per cycle
// depends on tlik_pkg
module tlik_cordic (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [tlik_pkg::NW+1:0] y_i,
  input  logic signed [tlik_pkg::NW+1:0] x_i,
  output logic                        busy_o,
  output logic signed [tlik_pkg::AngW+2:0] ang_o
);
  import tlik_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_NORM, S_ROT, S_FIN} st_e;
  localparam int MW = NW + 2;

  st_e st_q;
  logic [MW-1:0] ax_q, ay_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [ZW-1:0] z_q;
  logic [ItW-1:0] it_q;
  logic xneg_q, yneg_q, zero_q;
  logic signed [AngW+2:0] ang_q;
  logic [MW-1:0] m;
  logic signed [ZW-1:0] zf, mag;
  logic [ZW-1:0] rmag;
  logic signed [CW-1:0] dx, dy;

  assign m  = (ax_q > ay_q) ? ax_q : ay_q;
  assign dx = cy_q >>> it_q;
  assign dy = cx_q >>> it_q;
  assign zf = xneg_q ? PiQ30 - z_q : z_q;
  assign mag = zf[ZW-1] ? -zf : zf;
  assign rmag = (ZW'(mag) + (ZW'(1) << (29 - AngleFracBits))) >> (30 - AngleFracBits);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      case (st_q)
        S_IDLE: if (start_i) st_q <= S_NORM;
        S_NORM: begin
          if (zero_q) st_q <= S_FIN;
          else if (m < (MW'(1) << 30) && m >= (MW'(1) << 29)) st_q <= S_ROT;
        end
        S_ROT:  if (it_q == ItW'(CordicIters - 1)) st_q <= S_FIN;
        S_FIN:  st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: if (start_i) begin
        xneg_q <= x_i[MW-1];
        yneg_q <= y_i[MW-1];
        ax_q   <= x_i[MW-1] ? MW'(-x_i) : MW'(x_i);
        ay_q   <= y_i[MW-1] ? MW'(-y_i) : MW'(y_i);
        zero_q <= (x_i == '0) && (y_i == '0);
        it_q   <= '0;
        z_q    <= '0;
      end
      S_NORM: begin
        if (m >= (MW'(1) << 30)) begin
          ax_q <= ax_q >> 1; ay_q <= ay_q >> 1;
        end else if (m < (MW'(1) << 29)) begin
          ax_q <= ax_q << 1; ay_q <= ay_q << 1;
        end else begin
          cx_q <= CW'(ax_q); cy_q <= CW'(ay_q);
        end
      end
      S_ROT: begin
        if (!cy_q[CW-1]) begin
          cx_q <= cx_q + dx; cy_q <= cy_q - dy; z_q <= z_q + $signed(atan_q30(it_q));
        end else begin
          cx_q <= cx_q - dx; cy_q <= cy_q + dy; z_q <= z_q - $signed(atan_q30(it_q));
        end
        it_q <= it_q + 1'b1;
      end
      S_FIN: begin
        if (zero_q) ang_q <= '0;
        else if (zf[ZW-1] ^ yneg_q) ang_q <= -$signed((AngW+3)'(rmag));
        else ang_q <= $signed((AngW+3)'(rmag));
      end
      default: ;
    endcase
  end

  assign busy_o = (st_q != S_IDLE);
  assign ang_o  = ang_q;
endmodule

>>> src/tlik_datapath.sv
// datapath: elbow cosine terms, sqrt and cordic units, wrap and solution pick
// depends on tlik_pkg, tlik_sqrt, tlik_cordic
module tlik_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tlik_pkg::ctrl_t              ctrl_i,
  output tlik_pkg::stat_t              stat_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [tlik_pkg::LenW-1:0]    cfg_data_i,
  input  logic signed [tlik_pkg::CoordW-1:0] x_i,
  input  logic signed [tlik_pkg::CoordW-1:0] y_i,
  output logic [tlik_pkg::AngW-1:0]    shoulder_o,
  output logic [tlik_pkg::AngW-1:0]    elbow_o,
  output logic                         choice_o,
  output logic                         oor_o
);
  import tlik_pkg::*;

  localparam int AW = AngW + 3;

  logic [LenW-1:0] l1_q, l2_q;
  logic signed [CoordW-1:0] x_q, y_q;
  logic signed [NW-1:0] num_q, den_q, l1sq_q;
  logic oor_q, zlen_q;
  logic oor_out_q;
  logic [RootW-1:0] sn_q;
  logic signed [AW-1:0] base_q, e1_q, off1_q, cs_q, ce_q;
  logic choice_q;
  logic signed [NW-1:0] num_raw;

  logic sq_start, sq_busy, co_start, co_busy;
  logic [RootW-1:0] root;
  logic signed [NW+1:0] co_y, co_x;
  logic signed [AW-1:0] ang;

  assign num_raw = NW'(x_q * x_q) + NW'(y_q * y_q)
                 - NW'({1'b0, l1_q} * {1'b0, l1_q}) - NW'({1'b0, l2_q} * {1'b0, l2_q});

  // unsigned radicand den^2 - num^2, both magnitudes below 2^30 after clamp
  logic [RootW-1:0] den_mag, num_mag;
  logic [SqW-1:0] rad;
  assign den_mag = den_q[RootW-1:0];
  assign num_mag = num_q[NW-1] ? RootW'(-num_q) : RootW'(num_q);
  assign rad = SqW'(den_mag * den_mag) - SqW'(num_mag * num_mag);

  assign sq_start = (ctrl_i.cmd == CMD_SQRT);
  tlik_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i(rad), .busy_o(sq_busy), .root_o(root)
  );

  always_comb begin
    co_y = '0; co_x = '0;
    case (ctrl_i.cmd)
      CMD_ATAN_BASE: begin co_y = (NW+2)'(y_q); co_x = (NW+2)'(x_q); end
      CMD_ATAN_ELB:  begin co_y = (NW+2)'($signed({1'b0, sn_q})); co_x = (NW+2)'(num_q); end
      CMD_ATAN_OFF1: begin
        co_y = (NW+2)'($signed({1'b0, sn_q})); co_x = (NW+2)'(l1sq_q) + (NW+2)'(num_q);
      end
      CMD_ATAN_OFF2: begin
        co_y = -(NW+2)'($signed({1'b0, sn_q})); co_x = (NW+2)'(l1sq_q) + (NW+2)'(num_q);
      end
      default: ;
    endcase
  end
  assign co_start = (ctrl_i.cmd == CMD_ATAN_BASE) || (ctrl_i.cmd == CMD_ATAN_ELB)
                 || (ctrl_i.cmd == CMD_ATAN_OFF1) || (ctrl_i.cmd == CMD_ATAN_OFF2);
  tlik_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(co_start), .y_i(co_y), .x_i(co_x), .busy_o(co_busy), .ang_o(ang)
  );

  function automatic logic signed [AW-1:0] wrap(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] p;
    p = AW'(PiFmt);
    if (v > p) return v - (p <<< 1);
    else if (v < -p) return v + (p <<< 1);
    return v;
  endfunction

  // solution pick, runs when the second offset is back from the cordic
  logic signed [AW-1:0] s1, s2, e1, e2, d1, d2, d3, d4;
  logic signed [AW+1:0] cost1, cost2;
  always_comb begin
    e1 = zlen_q ? '0 : e1_q;
    e2 = zlen_q ? '0 : wrap(-e1_q);
    s1 = zlen_q ? base_q : wrap(base_q - off1_q);
    s2 = zlen_q ? base_q : wrap(base_q - ang);
    d1 = s1 - cs_q; d2 = e1 - ce_q; d3 = s2 - cs_q; d4 = e2 - ce_q;
    cost1 = (AW+2)'(d1[AW-1] ? -d1 : d1) + (AW+2)'(d2[AW-1] ? -d2 : d2);
    cost2 = (AW+2)'(d3[AW-1] ? -d3 : d3) + (AW+2)'(d4[AW-1] ? -d4 : d4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q <= LenW'(1000); l2_q <= LenW'(1000);
      cs_q <= '0; ce_q <= '0; choice_q <= 1'b0; oor_q <= 1'b0; oor_out_q <= 1'b0;
    end else begin
      if (cfg_we_i && !cfg_idx_i) l1_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i)  l2_q <= cfg_data_i;
      if (ctrl_i.cmd == CMD_NUM) begin
        oor_q <= zlen_q || (num_raw > den_q) || (num_raw < -den_q);
      end
      // the flag moves to the output word together with the chosen pose
      if (ctrl_i.pick) begin
        oor_out_q <= oor_q;
        if (cost1 < cost2) begin
          cs_q <= s1; ce_q <= e1; choice_q <= 1'b0;
        end else begin
          cs_q <= s2; ce_q <= e2; choice_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CMD_LOAD: begin
        x_q <= x_i; y_q <= y_i;
        zlen_q <= (l1_q == '0) || (l2_q == '0);
        den_q  <= NW'({1'b0, l1_q} * {1'b0, l2_q}) <<< 1;
        l1sq_q <= NW'({1'b0, l1_q} * {1'b0, l1_q}) <<< 1;
      end
      CMD_NUM: begin
        if (num_raw > den_q) num_q <= den_q;
        else if (num_raw < -den_q) num_q <= -den_q;
        else num_q <= num_raw;
      end
      CMD_ATAN_BASE: sn_q <= root;
      default: ;
    endcase
    // results land when the cordic drops busy, the controller labels them
    if (ctrl_i.cmd == CMD_ATAN_ELB)  base_q <= ang;
    if (ctrl_i.cmd == CMD_ATAN_OFF1) e1_q   <= wrap(ang);
    if (ctrl_i.cmd == CMD_ATAN_OFF2) off1_q <= ang;
  end

  assign stat_o.busy = sq_busy || co_busy;
  assign shoulder_o  = cs_q[AngW-1:0];
  assign elbow_o     = ce_q[AngW-1:0];
  assign choice_o    = choice_q;
  assign oor_o       = oor_out_q;
endmodule

>>> src/tlik_ctrl.sv
// sequencer for the inverse kinematics datapath and output handshake
// depends on tlik_pkg
module tlik_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  tlik_pkg::stat_t stat_i,
  output tlik_pkg::ctrl_t ctrl_o
);
  import tlik_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_NUM, S_SQRT, S_WSQ, S_BASE, S_WBASE, S_ELB, S_WELB,
    S_OFF1, S_WOFF1, S_OFF2, S_WOFF2, S_PICK
  } st_e;

  st_e st_q;
  logic out_valid_q;
  logic wait_q;
  logic adv;
  logic launch;
  logic pick_ok;

  // a new word may enter while the last result waits, but the pick stage
  // must not overwrite an untaken result
  assign in_ready_o = (st_q == S_IDLE);

  assign adv     = !stat_i.busy && wait_q;
  assign pick_ok = !out_valid_q || out_ready_i;
  // a unit is started this cycle, so skip one busy check
  assign launch  = (st_q == S_SQRT)
                || (adv && (st_q == S_WSQ || st_q == S_WBASE || st_q == S_WELB
                            || st_q == S_WOFF1));

  always_comb begin
    ctrl_o.cmd  = CMD_NONE;
    ctrl_o.pick = 1'b0;
    case (st_q)
      S_IDLE: if (in_valid_i) ctrl_o.cmd = CMD_LOAD;
      S_NUM:  ctrl_o.cmd = CMD_NUM;
      S_SQRT: ctrl_o.cmd = CMD_SQRT;
      S_WSQ:  if (adv) ctrl_o.cmd = CMD_ATAN_BASE;
      S_WBASE: if (adv) ctrl_o.cmd = CMD_ATAN_ELB;
      S_WELB:  if (adv) ctrl_o.cmd = CMD_ATAN_OFF1;
      S_WOFF1: if (adv) ctrl_o.cmd = CMD_ATAN_OFF2;
      S_PICK:  ctrl_o.pick = pick_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      out_valid_q <= 1'b0;
      wait_q <= 1'b0;
    end else begin
      wait_q <= !launch;
      if (st_q == S_PICK && pick_ok) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (st_q)
        S_IDLE: if (in_valid_i) st_q <= S_NUM;
        S_NUM:  st_q <= S_SQRT;
        S_SQRT: st_q <= S_WSQ;
        S_WSQ:  if (adv) st_q <= S_WBASE;
        S_WBASE: if (adv) st_q <= S_WELB;
        S_WELB:  if (adv) st_q <= S_WOFF1;
        S_WOFF1: if (adv) st_q <= S_WOFF2;
        S_WOFF2: if (adv) st_q <= S_PICK;
        S_PICK: if (pick_ok) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  a_pick_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.pick |-> (!out_valid_q || out_ready_i))
    else $error("pick would overwrite a pending result");
  a_valid_after_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.pick |=> out_valid_q)
    else $error("result not presented after pick");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.cmd == CMD_ATAN_BASE || ctrl_o.cmd == CMD_ATAN_ELB) |-> !stat_i.busy)
    else $error("unit started while busy");
endmodule

>>> src/two_link_inverse_kinematics.sv
// top level of the two-link planar arm inverse kinematics block
// depends on tlik_pkg, tlik_ctrl, tlik_datapath
//
// usage:
//   s_axis carries one target word (x, y in 0.1 mm units); m_axis returns one
//   word per target with the shoulder and elbow angles in q2.13 radians, the
//   chosen elbow branch and an out-of-reach flag.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the link lengths (index 0 upper arm,
//   index 1 forearm); write only while the block is idle.
// resources:
//   each of the four cordic atan2 passes first normalizes its operands, with
//   up to 29 shifts a pass; a pass on the origin skips the micro-rotations.
//   the 32-step square root and the four passes run on one shared sqrt unit
//   and one cordic unit; a new word is taken only when the previous one has
//   finished computing.
// reset:
//   rst_ni low clears the stored pose to zero and both lengths to 1000.
// stall:
//   a finished word is held on m_axis while m_axis_tready is low; the next
//   target can be accepted and computed meanwhile, and waits in its last
//   step until the output register frees.
module two_link_inverse_kinematics (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // target_x[15:0], target_y[31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // shoulder_angle[15:0], elbow_angle[31:16]
  output logic [1:0]  m_axis_tuser,   // elbow_choice[0], out_of_reach[1]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [13:0] cfg_data_i
);
  import tlik_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic [AngW-1:0] sh, el;
  logic ch, oor;

  tlik_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .stat_i(stat), .ctrl_o(ctrl)
  );

  tlik_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .x_i(s_axis_tdata[15:0]), .y_i(s_axis_tdata[31:16]),
    .shoulder_o(sh), .elbow_o(el), .choice_o(ch), .oor_o(oor)
  );

  assign m_axis_tdata = {el, sh};
  assign m_axis_tuser = {oor, ch};
endmodule

>>> dv/two_link_inverse_kinematics_test.sv
`timescale 1ns / 1ps
// self-checking bench for two_link_inverse_kinematics: directed table plus random targets
// checks every result word against a built-in integer ik predictor or a typed expectation; depends on tlik_pkg
module two_link_inverse_kinematics_test;
  import tlik_pkg::*;

  localparam int    CycleLimit = 1_500_000;
  localparam int    RandItems  = 1850;
  localparam int    IdleWait   = 200;   // settling margin once all results are back
  localparam longint PiOut     = (longint'(PiQ30) + (64'sd1 << (29 - AngleFracBits)))
                                 >>> (30 - AngleFracBits);

  typedef enum logic [1:0] {ROW_CFG, ROW_TARGET, ROW_CHECKED} row_kind_e;
  typedef enum logic {REG_UPPER = 1'b0, REG_FOREARM = 1'b1} reg_idx_e;

  typedef struct {
    row_kind_e    kind;
    logic  [15:0] a;      // x, or register index
    logic  [15:0] b;      // y, or register value
    logic  [15:0] shoulder;
    logic  [15:0] elbow;
    logic         choice;
    logic         oor;
  } row_t;

  typedef struct packed {
    logic [15:0] shoulder;
    logic [15:0] elbow;
    logic        choice;
    logic        oor;
  } pose_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;    // target_x[15:0], target_y[31:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // shoulder_angle[15:0], elbow_angle[31:16]
  logic [1:0]  m_axis_tuser;         // elbow_choice[0], out_of_reach[1]
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [13:0] cfg_data_i = '0;

  two_link_inverse_kinematics i_dut (.*);

  // predictor state: link lengths and last chosen pose
  longint link_upper, link_fore, pose_shoulder, pose_elbow;
  pose_t  pending_poses[$];
  int     failures;
  int     cycles;
  bit     quiet_sink;     // stretches where the sink never stalls
  bit     quiet_source;

  // q30 arctangent table
  localparam longint AtanTab[24] = '{
    843314857, 497837830, 263043837, 133525159, 67021687, 33543516, 16775851,
    8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(r);
  endfunction

  // vectoring cordic on normalized magnitudes, rounded to the output format
  function automatic longint arctan2(longint y, longint x);
    longint ax, ay, m, cx, cy, z, dx, dy, mag, r;
    if (x == 0 && y == 0) return 0;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    m = ax > ay ? ax : ay;
    z = 0;
    while (m >= (64'sd1 << 30)) begin
      ax >>= 1; ay >>= 1; m >>= 1;
    end
    while (m < (64'sd1 << 29)) begin
      ax <<= 1; ay <<= 1; m <<= 1;
    end
    cx = ax;
    cy = ay;
    for (int i = 0; i < CordicIters && i < 24; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += AtanTab[i];
      end else begin
        cx -= dx; cy += dy; z -= AtanTab[i];
      end
    end
    if (x < 0) z = longint'(PiQ30) - z;
    mag = z < 0 ? -z : z;
    r = (mag + (64'sd1 << (29 - AngleFracBits))) >>> (30 - AngleFracBits);
    if (z < 0) r = -r;
    return y < 0 ? -r : r;
  endfunction

  function automatic longint wrap_pi(longint v);
    if (v > PiOut) return v - 2 * PiOut;
    if (v < -PiOut) return v + 2 * PiOut;
    return v;
  endfunction

  function automatic longint abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  // solve one target, update the stored pose
  function automatic pose_t solve_target(logic signed [15:0] tx, logic signed [15:0] ty);
    longint x, y, base, s1, s2, e1, e2, num, den, root, b, cost1, cost2;
    pose_t  p;
    x = tx;
    y = ty;
    base = arctan2(y, x);
    p.oor = 1'b0;
    if (link_upper == 0 || link_fore == 0) begin
      // degenerate arm: both branches collapse onto the target bearing
      p.oor = 1'b1;
      e1 = 0; e2 = 0; s1 = base; s2 = base;
    end else begin
      num = x * x + y * y - link_upper * link_upper - link_fore * link_fore;
      den = 2 * link_upper * link_fore;
      if (num > den) begin
        num = den; p.oor = 1'b1;
      end else if (num < -den) begin
        num = -den; p.oor = 1'b1;
      end
      root = int_sqrt(longint'(den * den - num * num));
      e1 = wrap_pi(arctan2(root, num));
      e2 = wrap_pi(-e1);
      b = 2 * link_upper * link_upper + num;
      s1 = wrap_pi(base - arctan2(root, b));
      s2 = wrap_pi(base - arctan2(-root, b));
    end
    cost1 = abs_l(s1 - pose_shoulder) + abs_l(e1 - pose_elbow);
    cost2 = abs_l(s2 - pose_shoulder) + abs_l(e2 - pose_elbow);
    if (cost1 < cost2) begin
      pose_shoulder = s1; pose_elbow = e1; p.choice = 1'b0;
    end else begin
      pose_shoulder = s2; pose_elbow = e2; p.choice = 1'b1;  // ties go negative
    end
    p.shoulder = pose_shoulder[15:0];
    p.elbow    = pose_elbow[15:0];
    return p;
  endfunction

  // let the block drain fully before touching the lengths
  task automatic wait_idle();
    while (pending_poses.size() != 0) @(posedge clk_i);
    repeat (IdleWait) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_length(reg_idx_e idx, logic [13:0] value);
    wait_idle();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_UPPER) link_upper = value;
    else link_fore = value;
  endtask

  // one target word; a typed expectation overrides the predicted one
  task automatic send_target(logic [15:0] x, logic [15:0] y, bit typed, pose_t typed_pose);
    int    gap;
    pose_t p;
    gap = quiet_source ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata = {y, x};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    p = solve_target(x, y);
    pending_poses.push_back(typed ? typed_pose : p);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // sink: random stalls, compare each word with the oldest expectation
  initial begin
    pose_t exp_pose;
    int    stall;
    forever begin
      @(negedge clk_i);
      stall = quiet_sink ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (pending_poses.size() == 0) begin
        $error("unexpected word %h / %b", m_axis_tdata, m_axis_tuser);
        failures++;
      end else begin
        exp_pose = pending_poses.pop_front();
        if (m_axis_tdata[15:0] !== exp_pose.shoulder) begin
          $error("shoulder_angle exp %0d got %0d", $signed(exp_pose.shoulder),
                 $signed(m_axis_tdata[15:0]));
          failures++;
        end
        if (m_axis_tdata[31:16] !== exp_pose.elbow) begin
          $error("elbow_angle exp %0d got %0d", $signed(exp_pose.elbow),
                 $signed(m_axis_tdata[31:16]));
          failures++;
        end
        if (m_axis_tuser[0] !== exp_pose.choice) begin
          $error("elbow_choice exp %0b got %0b", exp_pose.choice, m_axis_tuser[0]);
          failures++;
        end
        if (m_axis_tuser[1] !== exp_pose.oor) begin
          $error("out_of_reach exp %0b got %0b", exp_pose.oor, m_axis_tuser[1]);
          failures++;
        end
      end
    end
  end

  // random target: mostly inside the workspace, some anywhere, near the origin or on an extreme
  task automatic random_target(output logic [15:0] x, output logic [15:0] y);
    int reach;
    reach = int'(link_upper + link_fore + 2);
    if (reach > 32767) reach = 32767;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        x = 16'($urandom_range(0, 2 * reach) - reach);
        y = 16'($urandom_range(0, 2 * reach) - reach);
      end
      6, 7: begin
        x = 16'($urandom);
        y = 16'($urandom);
      end
      8: begin
        x = 16'($urandom_range(0, 8) - 4);
        y = 16'($urandom_range(0, 8) - 4);
      end
      default: begin
        // one coordinate at a random extreme, the other zero or random
        x = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        y = $urandom_range(0, 1) ? 16'h0000 : 16'($urandom);
        if ($urandom_range(0, 1)) {x, y} = {y, x};
      end
    endcase
  endtask

  row_t directed[] = '{
    // origin after reset: folded arm, elbow at -pi, tie picks the negative branch
    '{ROW_CHECKED, 16'h0000, 16'h0000, 16'h0000, 16'h9b78, 1'b1, 1'b0},
    '{ROW_TARGET,  16'd2000, 16'h0000, '0, '0, 1'b0, 1'b0},  // fully stretched
    '{ROW_TARGET,  16'h7fff, 16'h7fff, '0, '0, 1'b0, 1'b0},
    '{ROW_TARGET,  16'h8000, 16'h8000, '0, '0, 1'b0, 1'b0},
    '{ROW_TARGET,  16'h8000, 16'h0000, '0, '0, 1'b0, 1'b0},
    '{ROW_TARGET,  16'h0000, 16'h7fff, '0, '0, 1'b0, 1'b0},
    '{ROW_TARGET,  16'd1000, 16'd1000, '0, '0, 1'b0, 1'b0},
    '{ROW_TARGET,  16'hfc18, 16'd1000, '0, '0, 1'b0, 1'b0},
    '{ROW_TARGET,  16'd1000, 16'hfc18, '0, '0, 1'b0, 1'b0},
    '{ROW_TARGET,  16'd0500, 16'd0300, '0, '0, 1'b0, 1'b0},
    // zero upper arm: degenerate, always out of reach
    '{ROW_CFG,     REG_UPPER, 16'd0,   '0, '0, 1'b0, 1'b0},
    '{ROW_TARGET,  16'd0700, 16'hff00, '0, '0, 1'b0, 1'b0},
    '{ROW_CHECKED, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1},
    '{ROW_CFG,     REG_UPPER, 16'd1000, '0, '0, 1'b0, 1'b0},
    '{ROW_CFG,     REG_FOREARM, 16'd0, '0, '0, 1'b0, 1'b0},
    '{ROW_TARGET,  16'hf000, 16'h0123, '0, '0, 1'b0, 1'b0},
    // unequal links, then both at the longest length
    '{ROW_CFG,     REG_FOREARM, 16'd16383, '0, '0, 1'b0, 1'b0},
    '{ROW_TARGET,  16'h0000, 16'h0000, '0, '0, 1'b0, 1'b0},
    '{ROW_TARGET,  16'd15383, 16'h0000, '0, '0, 1'b0, 1'b0},
    '{ROW_CFG,     REG_UPPER, 16'd16383, '0, '0, 1'b0, 1'b0},
    '{ROW_TARGET,  16'h0000, 16'h0000, '0, '0, 1'b0, 1'b0},
    '{ROW_TARGET,  16'h7fff, 16'h8000, '0, '0, 1'b0, 1'b0},
    '{ROW_CFG,     REG_UPPER, 16'd1, '0, '0, 1'b0, 1'b0},
    '{ROW_CFG,     REG_FOREARM, 16'd1, '0, '0, 1'b0, 1'b0},
    '{ROW_TARGET,  16'd0002, 16'h0000, '0, '0, 1'b0, 1'b0}
  };

  // random phases, one length setting each
  logic [13:0] phase_len[6][2] = '{
    '{14'd1000, 14'd1000}, '{14'd1, 14'd1}, '{14'd16383, 14'd16383},
    '{14'd3000, 14'd1200}, '{14'd20, 14'd9000}, '{14'd0, 14'd0}};

  initial begin
    logic [15:0] x, y;
    pose_t       typed_pose;
    link_upper = 1000;
    link_fore = 1000;
    pose_shoulder = 0;
    pose_elbow = 0;
    failures = 0;
    cycles = 0;
    quiet_sink = 1'b0;
    quiet_source = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        write_length(reg_idx_e'(directed[i].a[0]), directed[i].b[13:0]);
      end else begin
        typed_pose = '{directed[i].shoulder, directed[i].elbow, directed[i].choice,
                       directed[i].oor};
        send_target(directed[i].a, directed[i].b, directed[i].kind == ROW_CHECKED,
                    typed_pose);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 6) begin
        write_length(REG_UPPER, phase_len[ph][0]);
        write_length(REG_FOREARM, phase_len[ph][1]);
      end else begin
        write_length(REG_UPPER, 14'($urandom_range(1, 16383)));
        write_length(REG_FOREARM, 14'($urandom_range(1, 16383)));
      end
      // the degenerate phase stays short
      for (int n = 0; n < (ph == 5 ? 50 : (RandItems - 50) / 7); n++) begin
        if (n % 64 == 0) begin
          quiet_sink = ($urandom_range(0, 3) == 0);
          quiet_source = ($urandom_range(0, 3) == 0);
        end
        random_target(x, y);
        send_target(x, y, 1'b0, typed_pose);
      end
    end
    s_axis_tvalid = 1'b0;

    while (pending_poses.size() != 0) @(posedge clk_i);
    repeat (IdleWait) @(posedge clk_i);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
